// File: rtl/core/wia_pkg.sv
// Package for the wide integer arithmetic unit.
// Operation, status and order codes and the word width.
// No dependencies.
package wia_pkg;

    localparam int WORD_BITS = 32;

    typedef enum logic [2:0] {
        OP_LOAD_A  = 3'd0,
        OP_LOAD_B  = 3'd1,
        OP_ADD     = 3'd2,
        OP_SUB     = 3'd3,
        OP_MUL     = 3'd4,
        OP_QUOT    = 3'd5,
        OP_REM     = 3'd6,
        OP_COMPARE = 3'd7
    } op_t;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_BORROW = 2'd1;
    localparam logic [1:0] STATUS_DIV0   = 2'd2;

    localparam logic [1:0] ORDER_LESS    = 2'd0;
    localparam logic [1:0] ORDER_EQUAL   = 2'd1;
    localparam logic [1:0] ORDER_GREATER = 2'd2;

endpackage

// File: rtl/core/wide_integer_arith_unit.sv
// Wide unsigned integer arithmetic unit, top level.
// Shared (N+2)-bit adder/subtractor under a small sequencer; uses wia_pkg.
//
// Usage: the s_ channel takes one word per handshake. Loads (operation 0/1)
// write one 32-bit word of operand A or B at s_word_index; an index at or
// above WORDS is dropped. Loads return nothing.
// Run operations return WORDS words on the m_ channel, least significant
// first, m_last_word on the top one, with m_status and m_order repeated.
// Every run starts with an A-B step that sets order and the sub borrow.
// After the A-B step, sub and compare go to output, add via ST_ADD, and
// mul, quotient and remainder take N = 32*WORDS bits one bit per cycle
// through the shared adder. Then one word per cycle while m_ready is high.
// s_ready is low from a run's accept until its last word is taken; a
// stalled receiver holds the block with the current word steady.
// Reset (synchronous, active low) clears both operands and the sequencer.
module wide_integer_arith_unit
    import wia_pkg::*;
#(
    parameter int WORDS = 5
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_operation,
    input  logic [2:0]           s_word_index,
    input  logic [WORD_BITS-1:0] s_word_value,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_result_index,
    output logic [WORD_BITS-1:0] m_result_word,
    output logic                 m_last_word,
    output logic [1:0]           m_status,
    output logic [1:0]           m_order
);

    localparam int N    = WORD_BITS * WORDS;
    localparam int CNTW = $clog2(N);
    localparam int IW   = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int OCW  = (IW < 3) ? 3 : IW;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_ADD,
        ST_MUL,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t            state_reg;
    op_t               op_reg;
    logic [N-1:0]      a_reg;
    logic [N-1:0]      b_reg;
    logic [N-1:0]      res_reg;
    logic [N-1:0]      shf_reg;
    logic [CNTW-1:0]   cnt_reg;
    logic [OCW-1:0]    ocnt_reg;
    logic [1:0]        status_reg;
    logic [1:0]        order_reg;

    // shared adder
    logic [N:0]        add_x;
    logic [N:0]        add_y;
    logic              add_sub;
    logic [N+1:0]      add_sum;
    logic              no_borrow;

    always_comb begin
        add_x   = {1'b0, a_reg};
        add_y   = {1'b0, b_reg};
        add_sub = 1'b1;
        unique case (state_reg)
            ST_ADD: begin
                add_sub = 1'b0;
            end
            ST_MUL: begin
                add_x   = {2'b00, res_reg[N-2:0]};
                add_x   = add_x << 1;
                add_y   = shf_reg[N-1] ? {1'b0, a_reg} : '0;
                add_sub = 1'b0;
            end
            ST_DIV: begin
                add_x = {res_reg, shf_reg[N-1]};
            end
            default: begin
            end
        endcase
    end

    assign add_sum   = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)}
                     + {{(N+1){1'b0}}, add_sub};
    assign no_borrow = add_sum[N+1];

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = (state_reg == ST_OUT);
    assign m_result_index = ocnt_reg[2:0];
    assign m_result_word  = res_reg[WORD_BITS-1:0];
    assign m_last_word    = (ocnt_reg == OCW'(WORDS - 1));
    assign m_status       = status_reg;
    assign m_order        = order_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            a_reg     <= '0;
            b_reg     <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg <= op_t'(s_operation);
                        unique case (op_t'(s_operation))
                            OP_LOAD_A: begin
                                for (int k = 0; k < WORDS; k++) begin
                                    if (int'(s_word_index) == k) begin
                                        a_reg[k*WORD_BITS +: WORD_BITS] <= s_word_value;
                                    end
                                end
                            end
                            OP_LOAD_B: begin
                                for (int k = 0; k < WORDS; k++) begin
                                    if (int'(s_word_index) == k) begin
                                        b_reg[k*WORD_BITS +: WORD_BITS] <= s_word_value;
                                    end
                                end
                            end
                            default: begin
                                state_reg <= ST_CMP;
                            end
                        endcase
                    end
                end
                ST_CMP: begin
                    res_reg    <= add_sum[N-1:0];
                    ocnt_reg   <= '0;
                    cnt_reg    <= CNTW'(N - 1);
                    status_reg <= STATUS_OK;
                    if (!no_borrow) begin
                        order_reg <= ORDER_LESS;
                    end else if (add_sum[N-1:0] == '0) begin
                        order_reg <= ORDER_EQUAL;
                    end else begin
                        order_reg <= ORDER_GREATER;
                    end
                    unique case (op_reg) inside
                        OP_ADD: begin
                            state_reg <= ST_ADD;
                        end
                        OP_SUB: begin
                            if (!no_borrow) begin
                                status_reg <= STATUS_BORROW;
                            end
                            state_reg <= ST_OUT;
                        end
                        OP_MUL: begin
                            res_reg   <= '0;
                            shf_reg   <= b_reg;
                            state_reg <= ST_MUL;
                        end
                        OP_QUOT, OP_REM: begin
                            res_reg <= '0;
                            shf_reg <= a_reg;
                            if (b_reg == '0) begin
                                status_reg <= STATUS_DIV0;
                            end
                            state_reg <= ST_DIV;
                        end
                        default: begin
                            res_reg   <= '0;
                            state_reg <= ST_OUT;
                        end
                    endcase
                end
                ST_ADD: begin
                    res_reg   <= add_sum[N-1:0];
                    state_reg <= ST_OUT;
                end
                ST_MUL: begin
                    res_reg <= add_sum[N-1:0];
                    shf_reg <= shf_reg << 1;
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_OUT;
                    end
                end
                ST_DIV: begin
                    // keep trial difference when the shifted-out top bit is set
                    // or no borrow occurred
                    if (res_reg[N-1] || no_borrow) begin
                        res_reg <= add_sum[N-1:0];
                    end else begin
                        res_reg <= add_x[N-1:0];
                    end
                    shf_reg <= {shf_reg[N-2:0], (res_reg[N-1] | no_borrow)};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= ST_OUT;
                        if (op_reg == OP_QUOT) begin
                            res_reg <= {shf_reg[N-2:0], (res_reg[N-1] | no_borrow)};
                        end
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        res_reg  <= res_reg >> WORD_BITS;
                        ocnt_reg <= ocnt_reg + 1'b1;
                        if (ocnt_reg == OCW'(WORDS - 1)) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
